// ----- hw/rtl/clcs_pkg.sv -----
`timescale 1ns / 1ps
package clcs_pkg;

    // field widths
    localparam int RANGE_W = 19;
    localparam int A0_W    = 16;
    localparam int C1_W    = 22;
    localparam int C2_W    = 31;
    localparam int C3_W    = 36;
    localparam int X_W     = 19;
    localparam int Y_W     = 32;

    // config widths
    localparam int VIEW_W  = 18;
    localparam int BACK_W  = 16;
    localparam int STEP_W  = 18;

    // back length + clamped range
    localparam int LIM_W   = 19;

    // evaluation abscissa: -back .. -back + 3*step
    localparam int XE_W    = 21;

    // Q60 accumulator, enough for |P(x)| < 2^97 at |x| < 2^20
    localparam int ACC_W   = 98;
    localparam int RND_POS = 60;
    localparam int SH_C1   = 40;
    localparam int SH_C2   = 20;

    // job queue
    localparam int Q_DEPTH = 2;

    // APB map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = 2;

    localparam logic [RIDX_W-1:0] REG_LOW_VIEW   = 2'd0;
    localparam logic [RIDX_W-1:0] REG_UPPER_VIEW = 2'd1;
    localparam logic [RIDX_W-1:0] REG_BACK_LEN   = 2'd2;
    localparam logic [RIDX_W-1:0] REG_STEP_DIST  = 2'd3;

    localparam logic [VIEW_W-1:0] RST_LOW_VIEW   = 18'd10240;
    localparam logic [VIEW_W-1:0] RST_UPPER_VIEW = 18'd102400;
    localparam logic [BACK_W-1:0] RST_BACK_LEN   = 16'd0;
    localparam logic [STEP_W-1:0] RST_STEP_DIST  = 18'd1024;

    typedef struct packed {
        logic [A0_W-1:0]  a0;
        logic [C1_W-1:0]  c1;
        logic [C2_W-1:0]  c2;
        logic [C3_W-1:0]  c3;
        logic [LIM_W-1:0] lim;
        logic             cut;
    } t_job;

    // zero step behaves as a step of one
    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] step);
        return (step == '0) ? STEP_W'(1) : step;
    endfunction

endpackage

// ----- hw/rtl/clcs_fifo.sv -----
`timescale 1ns / 1ps
module clcs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  clcs_pkg::t_job   i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_vld,
    output clcs_pkg::t_job   o_rdata
);

    localparam int PTR_W = $clog2(clcs_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(clcs_pkg::Q_DEPTH + 1);

    clcs_pkg::t_job   r_mem [clcs_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(clcs_pkg::Q_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(clcs_pkg::Q_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(clcs_pkg::Q_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- hw/rtl/clcs_front.sv -----
`timescale 1ns / 1ps
module clcs_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [clcs_pkg::RANGE_W-1:0] i_view_range,
    input  logic signed [clcs_pkg::A0_W-1:0]    i_offset_a0,
    input  logic signed [clcs_pkg::C1_W-1:0]    i_heading_c1,
    input  logic signed [clcs_pkg::C2_W-1:0]    i_curvature_c2,
    input  logic signed [clcs_pkg::C3_W-1:0]    i_curvature_rate_c3,
    input  logic [clcs_pkg::VIEW_W-1:0]         i_low_view_range,
    input  logic [clcs_pkg::VIEW_W-1:0]         i_upper_view_range,
    input  logic [clcs_pkg::BACK_W-1:0]         i_back_length,
    input  logic [clcs_pkg::STEP_W-1:0]         i_step_distance,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output clcs_pkg::t_job                      o_q_data
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PROD_W = clcs_pkg::STEP_W + CNT_W;

    logic                                r_vld, n_vld;
    clcs_pkg::t_job                      r_job;
    logic                                accept;
    logic signed [clcs_pkg::RANGE_W-1:0] lo_s, hi_s;
    logic [clcs_pkg::VIEW_W-1:0]         rng;
    logic [clcs_pkg::LIM_W-1:0]          lim;
    logic [clcs_pkg::STEP_W-1:0]         h;
    logic [PROD_W-1:0]                   span;

    assign o_busy   = r_vld && i_q_full;
    assign accept   = i_start && !o_busy;
    assign o_q_push = r_vld && !i_q_full;

    // clamp: low limit wins over upper when both apply
    always_comb begin
        lo_s = $signed({1'b0, i_low_view_range});
        hi_s = $signed({1'b0, i_upper_view_range});
        priority if (i_view_range < lo_s) begin
            rng = i_low_view_range;
        end else if (i_view_range > hi_s) begin
            rng = i_upper_view_range;
        end else begin
            rng = i_view_range[clcs_pkg::VIEW_W-1:0];
        end
        lim = {1'b0, rng} + {{(clcs_pkg::LIM_W - clcs_pkg::BACK_W){1'b0}}, i_back_length};
    end

    // run is cut when MAX_POINTS steps still fit inside the limit
    always_comb begin
        h        = clcs_pkg::eff_step(i_step_distance);
        span     = PROD_W'(MAX_POINTS) * {{CNT_W{1'b0}}, h};
        o_q_data = r_job;
        o_q_data.cut = (span <= PROD_W'(r_job.lim));
    end

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.a0  <= i_offset_a0;
            r_job.c1  <= i_heading_c1;
            r_job.c2  <= i_curvature_c2;
            r_job.c3  <= i_curvature_rate_c3;
            r_job.lim <= lim;
            r_job.cut <= 1'b0;
        end
    end

endmodule

// ----- hw/rtl/clcs_back.sv -----
`timescale 1ns / 1ps
module clcs_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_vld,
    input  clcs_pkg::t_job                    i_q_data,
    output logic                              o_q_pop,
    input  logic [clcs_pkg::BACK_W-1:0]       i_back_length,
    input  logic [clcs_pkg::STEP_W-1:0]       i_step_distance,
    output logic                              o_valid,
    output logic signed [clcs_pkg::X_W-1:0]   o_x_position,
    output logic signed [clcs_pkg::Y_W-1:0]   o_y_position,
    output logic                              o_last_point,
    output logic                              o_truncated
);

    localparam int ACC_W = clcs_pkg::ACC_W;
    localparam int XE_W  = clcs_pkg::XE_W;
    localparam int LIM_W = clcs_pkg::LIM_W;
    localparam int Y_W   = clcs_pkg::Y_W;
    localparam int X_W   = clcs_pkg::X_W;
    localparam int Q_W   = ACC_W - clcs_pkg::RND_POS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int BIT_W = $clog2(XE_W);

    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(XE_W - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FOLD = 3'd2;
    localparam logic [2:0] S_DIFF = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // coefficient terms aligned to Q60
    function automatic logic signed [ACC_W-1:0] term_a(input clcs_pkg::t_job j);
        return {{(ACC_W - clcs_pkg::A0_W - clcs_pkg::RND_POS){j.a0[clcs_pkg::A0_W-1]}},
                j.a0, {clcs_pkg::RND_POS{1'b0}}};
    endfunction

    function automatic logic signed [ACC_W-1:0] term_b(input clcs_pkg::t_job j);
        return {{(ACC_W - clcs_pkg::C1_W - clcs_pkg::SH_C1){j.c1[clcs_pkg::C1_W-1]}},
                j.c1, {clcs_pkg::SH_C1{1'b0}}};
    endfunction

    function automatic logic signed [ACC_W-1:0] term_c(input clcs_pkg::t_job j);
        return {{(ACC_W - clcs_pkg::C2_W - clcs_pkg::SH_C2){j.c2[clcs_pkg::C2_W-1]}},
                j.c2, {clcs_pkg::SH_C2{1'b0}}};
    endfunction

    function automatic logic signed [ACC_W-1:0] term_d(input clcs_pkg::t_job j);
        return {{(ACC_W - clcs_pkg::C3_W){j.c3[clcs_pkg::C3_W-1]}}, j.c3};
    endfunction

    logic [2:0]               r_state, n_state;
    clcs_pkg::t_job           r_job, n_job;
    logic signed [XE_W-1:0]   r_xe, n_xe;
    logic [1:0]               r_k, n_k;
    logic [1:0]               r_j, n_j;
    logic [1:0]               r_d, n_d;
    logic [BIT_W-1:0]         r_cnt, n_cnt;
    logic signed [ACC_W-1:0]  r_mul, n_mul;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [ACC_W-1:0]  r_p [4];
    logic signed [ACC_W-1:0]  n_p [4];
    logic [LIM_W-1:0]         r_pos, n_pos;
    logic [CNT_W-1:0]         r_i, n_i;
    logic                     r_valid, n_valid;
    logic signed [X_W-1:0]    r_x, n_x;
    logic signed [Y_W-1:0]    r_y, n_y;
    logic                     r_last, n_last;
    logic                     r_trunc, n_trunc;

    logic [clcs_pkg::STEP_W-1:0] h;
    logic                        x_bit;
    logic signed [ACC_W-1:0]     fold_coef;
    logic signed [ACC_W-1:0]     fold_sum;
    logic [LIM_W:0]              pos_next;
    logic signed [LIM_W:0]       x_diff;
    logic                        last;
    logic signed [Q_W-1:0]       q;
    logic signed [Y_W-1:0]       y_sat;

    assign o_q_pop      = (r_state == S_IDLE) && i_q_vld;
    assign o_valid      = r_valid;
    assign o_x_position = r_x;
    assign o_y_position = r_y;
    assign o_last_point = r_last;
    assign o_truncated  = r_trunc;

    assign h     = clcs_pkg::eff_step(i_step_distance);
    assign x_bit = r_xe[r_cnt];

    // Horner: after pass j add c2, c1, a0 terms in that order
    always_comb begin
        unique case (r_j)
            2'd0:    fold_coef = term_c(r_job);
            2'd1:    fold_coef = term_b(r_job);
            default: fold_coef = term_a(r_job);
        endcase
        fold_sum = r_acc + fold_coef;
    end

    // point bookkeeping and round-to-nearest (ties up) with saturation
    always_comb begin
        pos_next = {1'b0, r_pos} + {{(LIM_W + 1 - clcs_pkg::STEP_W){1'b0}}, h};
        last     = (r_i == CNT_W'(MAX_POINTS - 1)) || (pos_next > {1'b0, r_job.lim});
        x_diff   = $signed({1'b0, r_pos})
                 - $signed({{(LIM_W + 1 - clcs_pkg::BACK_W){1'b0}}, i_back_length});
        q        = r_p[0][ACC_W-1:clcs_pkg::RND_POS]
                 + {{(Q_W - 1){1'b0}}, r_p[0][clcs_pkg::RND_POS-1]};
        if (q[Q_W-1:Y_W-1] == '0 || q[Q_W-1:Y_W-1] == '1) begin
            y_sat = q[Y_W-1:0];
        end else if (q[Q_W-1]) begin
            y_sat = {1'b1, {(Y_W - 1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(Y_W - 1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_xe    = r_xe;
        n_k     = r_k;
        n_j     = r_j;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_mul   = r_mul;
        n_acc   = r_acc;
        n_p     = r_p;
        n_pos   = r_pos;
        n_i     = r_i;
        n_valid = 1'b0;
        n_x     = r_x;
        n_y     = r_y;
        n_last  = r_last;
        n_trunc = r_trunc;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    n_job   = i_q_data;
                    n_mul   = term_d(i_q_data);
                    n_xe    = -$signed({{(XE_W - clcs_pkg::BACK_W){1'b0}}, i_back_length});
                    n_k     = '0;
                    n_j     = '0;
                    n_cnt   = BIT_TOP;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // MSB-first shift-add, sign bit carries negative weight
                if (r_cnt == BIT_TOP) begin
                    n_acc = x_bit ? -r_mul : '0;
                end else begin
                    n_acc = (r_acc <<< 1) + (x_bit ? r_mul : '0);
                end
                if (r_cnt == '0) begin
                    n_state = S_FOLD;
                end else begin
                    n_cnt = r_cnt - BIT_W'(1);
                end
            end
            S_FOLD: begin
                n_cnt = BIT_TOP;
                if (r_j == 2'd2) begin
                    // value at this abscissa done: shift into sample table
                    n_p[0] = r_p[1];
                    n_p[1] = r_p[2];
                    n_p[2] = r_p[3];
                    n_p[3] = fold_sum;
                    n_xe   = r_xe + $signed({{(XE_W - clcs_pkg::STEP_W){1'b0}}, h});
                    n_mul  = term_d(r_job);
                    n_j    = '0;
                    if (r_k == 2'd3) begin
                        n_d     = '0;
                        n_state = S_DIFF;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_MUL;
                    end
                end else begin
                    n_mul   = fold_sum;
                    n_j     = r_j + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_DIFF: begin
                // three passes turn samples into forward differences
                for (int i = 1; i < 4; i++) begin
                    if (2'(i) > r_d) begin
                        n_p[i] = r_p[i] - r_p[i-1];
                    end
                end
                if (r_d == 2'd2) begin
                    n_pos   = '0;
                    n_i     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_d = r_d + 2'd1;
                end
            end
            S_EMIT: begin
                n_valid = 1'b1;
                n_x     = x_diff[X_W-1:0];
                n_y     = y_sat;
                n_last  = last;
                n_trunc = r_job.cut;
                n_p[0]  = r_p[0] + r_p[1];
                n_p[1]  = r_p[1] + r_p[2];
                n_p[2]  = r_p[2] + r_p[3];
                n_pos   = pos_next[LIM_W-1:0];
                n_i     = r_i + CNT_W'(1);
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_xe    <= n_xe;
        r_k     <= n_k;
        r_j     <= n_j;
        r_d     <= n_d;
        r_cnt   <= n_cnt;
        r_mul   <= n_mul;
        r_acc   <= n_acc;
        r_p     <= n_p;
        r_pos   <= n_pos;
        r_i     <= n_i;
        r_x     <= n_x;
        r_y     <= n_y;
        r_last  <= n_last;
        r_trunc <= n_trunc;
    end

endmodule

// ----- hw/rtl/cubic_lane_curve_sampler.sv -----
`timescale 1ns / 1ps
// Path from an accepted start to the first point: front stage, queue, then bit-serial
//   Horner evaluation (4 abscissas x 3 passes) and 3 difference passes; after that
//   one point per cycle, n points in a run.
// Curves are evaluated one at a time by the shared serial multiplier.
// Reset (i_rst_n low, synchronous): config registers to defaults, queue and control idle.
// Results are single-cycle strobes on o_valid; the receiver cannot stall.
module cubic_lane_curve_sampler #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [clcs_pkg::RANGE_W-1:0]   i_view_range,
    input  logic signed [clcs_pkg::A0_W-1:0]      i_offset_a0,
    input  logic signed [clcs_pkg::C1_W-1:0]      i_heading_c1,
    input  logic signed [clcs_pkg::C2_W-1:0]      i_curvature_c2,
    input  logic signed [clcs_pkg::C3_W-1:0]      i_curvature_rate_c3,

    // result channel
    output logic                                  o_valid,
    output logic signed [clcs_pkg::X_W-1:0]       o_x_position,
    output logic signed [clcs_pkg::Y_W-1:0]       o_y_position,
    output logic                                  o_last_point,
    output logic                                  o_truncated,

    // APB config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [clcs_pkg::PADDR_W-1:0]          paddr,
    input  logic [clcs_pkg::PDATA_W-1:0]          pwdata,
    output logic [clcs_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    // Config registers. Writes happen only while the block is idle; the block
    // does not enforce it. Front and back read them live without shadow copies.
    logic [clcs_pkg::VIEW_W-1:0] r_low_view, r_upper_view;
    logic [clcs_pkg::BACK_W-1:0] r_back_len;
    logic [clcs_pkg::STEP_W-1:0] r_step_dist;
    logic [clcs_pkg::RIDX_W-1:0] reg_idx;
    logic                        wr_xfer;

    // front <-> queue <-> back
    logic           q_push, q_full, q_pop, q_vld;
    clcs_pkg::t_job q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[clcs_pkg::PADDR_W-1:2];
    assign wr_xfer = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_view   <= clcs_pkg::RST_LOW_VIEW;
            r_upper_view <= clcs_pkg::RST_UPPER_VIEW;
            r_back_len   <= clcs_pkg::RST_BACK_LEN;
            r_step_dist  <= clcs_pkg::RST_STEP_DIST;
        end else if (wr_xfer) begin
            unique case (reg_idx)
                clcs_pkg::REG_LOW_VIEW:   r_low_view   <= pwdata[clcs_pkg::VIEW_W-1:0];
                clcs_pkg::REG_UPPER_VIEW: r_upper_view <= pwdata[clcs_pkg::VIEW_W-1:0];
                clcs_pkg::REG_BACK_LEN:   r_back_len   <= pwdata[clcs_pkg::BACK_W-1:0];
                clcs_pkg::REG_STEP_DIST:  r_step_dist  <= pwdata[clcs_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux, zero-extended to the bus
    always_comb begin
        unique case (reg_idx)
            clcs_pkg::REG_LOW_VIEW:
                prdata = clcs_pkg::PDATA_W'(r_low_view);
            clcs_pkg::REG_UPPER_VIEW:
                prdata = clcs_pkg::PDATA_W'(r_upper_view);
            clcs_pkg::REG_BACK_LEN:
                prdata = clcs_pkg::PDATA_W'(r_back_len);
            clcs_pkg::REG_STEP_DIST:
                prdata = clcs_pkg::PDATA_W'(r_step_dist);
            default:
                prdata = '0;
        endcase
    end

    // Front: takes the command, clamps the view range, forms the sampling
    // limit (back length + range) and flags runs that hit MAX_POINTS.
    clcs_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .o_busy              (busy),
        .i_view_range        (i_view_range),
        .i_offset_a0         (i_offset_a0),
        .i_heading_c1        (i_heading_c1),
        .i_curvature_c2      (i_curvature_c2),
        .i_curvature_rate_c3 (i_curvature_rate_c3),
        .i_low_view_range    (r_low_view),
        .i_upper_view_range  (r_upper_view),
        .i_back_length       (r_back_len),
        .i_step_distance     (r_step_dist),
        .i_q_full            (q_full),
        .o_q_push            (q_push),
        .o_q_data            (q_wdata)
    );

    // Two-entry job queue so a new command can be taken while a run is going.
    clcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_rdata (q_rdata)
    );

    // Back: evaluates the cubic exactly at the first four sample positions
    // with a serial multiplier, converts to forward differences, then walks
    // the curve with adds only, one rounded point per cycle.
    clcs_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_data        (q_rdata),
        .o_q_pop         (q_pop),
        .i_back_length   (r_back_len),
        .i_step_distance (r_step_dist),
        .o_valid         (o_valid),
        .o_x_position    (o_x_position),
        .o_y_position    (o_y_position),
        .o_last_point    (o_last_point),
        .o_truncated     (o_truncated)
    );

endmodule
